[design/stwie_pkg.sv]
`default_nettype none

package stwie_pkg;

    // table geometry and reset values
    localparam int SESSIONS_DEF = 4;
    localparam logic [15:0] REF_START = 16'h0021;
    localparam logic [39:0] TIMEOUT_RESET = 40'd120000;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;
    localparam logic REG_SERVER_SOCKET = 1'b0;
    localparam logic REG_IDLE_TIMEOUT  = 1'b1;

    // result kinds
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    typedef enum logic [2:0] {
        CMD_OPEN      = 3'd0,
        CMD_CLOSE     = 3'd1,
        CMD_TOUCH     = 3'd2,
        CMD_SWEEP     = 3'd3,
        CMD_CLOSE_ALL = 3'd4,
        CMD_QUERY     = 3'd5,
        CMD_SLOT_INFO = 3'd6,
        CMD_LOAD_REF  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_REPLY_RD,
        S_REPLY
    } eng_state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [39:0] now_time;
        logic [15:0] full_ref;
        logic [7:0]  short_id;
        logic [1:0]  slot_index;
        logic [7:0]  peer_node;
        logic [7:0]  client_socket;
        logic [15:0] proto_version;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [15:0] ref_out;
        logic [7:0]  id_out;
        logic [7:0]  socket_out;
        logic [7:0]  node_out;
        logic [7:0]  wss_out;
        logic [15:0] version_out;
        logic [39:0] idle_time;
        logic        any_open;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  server_socket;
        logic [39:0] idle_timeout;
    } cfg_t;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [15:0] sref;
        logic [7:0]  node;
        logic [7:0]  wss;
        logic [15:0] version;
        logic [39:0] last_seen;
    } slot_t;

endpackage

`default_nettype wire

[design/stwie_cfg_regs.sv]
`default_nettype none

module stwie_cfg_regs
    import stwie_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [7:0]  server_socket_reg;
    logic [39:0] idle_timeout_reg;
    logic        wr_en;

    // registers sit on 8-byte boundaries
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_socket_reg <= 8'd0;
            idle_timeout_reg  <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[3] == REG_SERVER_SOCKET)
                server_socket_reg <= pwdata[7:0];
            else
                idle_timeout_reg <= pwdata[39:0];
        end
    end

    always_comb
    begin
        if (paddr[3] == REG_SERVER_SOCKET)
            prdata = {56'd0, server_socket_reg};
        else
            prdata = {24'd0, idle_timeout_reg};
    end

    assign cfg.server_socket = server_socket_reg;
    assign cfg.idle_timeout  = idle_timeout_reg;

endmodule

`default_nettype wire

[design/stwie_engine.sv]
`default_nettype none

module stwie_engine
    import stwie_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  item_t     item,
    input  cfg_t      cfg,
    output logic      busy,
    output logic      res_strobe,
    output result_t   res
);

    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    function automatic logic [IW-1:0] low_idx(input logic [SESSIONS-1:0] m);
        logic [IW-1:0] r;
        r = '0;
        for (int i = SESSIONS - 1; i >= 0; i--)
            if (m[i])
                r = IW'(i);
        return r;
    endfunction

    eng_state_t          state_reg, state_next;
    item_t               item_reg;
    logic [IW-1:0]       idx_reg;
    logic [SESSIONS-1:0] mask_reg;
    logic [SESSIONS-1:0] mask_next;
    logic [SESSIONS-1:0] valid_reg;
    logic [15:0]         next_ref_reg;
    slot_t               rd_data_reg;
    slot_t               slot_mem [SESSIONS];

    cmd_t                cmd;
    logic                notice_cmd;
    logic                scan_last;
    logic                slot_match;
    logic                vld;
    logic [IW-1:0]       emit_idx;
    logic [SESSIONS-1:0] emit_rest;
    logic                free_any;
    logic [IW-1:0]       free_idx;
    logic [39:0]         idle_val;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    slot_t               wr_data;

    assign cmd        = cmd_t'(item_reg.command);
    assign notice_cmd = (cmd == CMD_CLOSE) || (cmd == CMD_SWEEP) || (cmd == CMD_CLOSE_ALL);
    assign scan_last  = (idx_reg == IW'(SESSIONS - 1));
    assign vld        = valid_reg[idx_reg];
    assign emit_idx   = low_idx(mask_reg);
    assign emit_rest  = mask_reg & ~(SESSIONS'(1) << emit_idx);
    assign free_any   = ~&valid_reg;
    assign free_idx   = low_idx(~valid_reg);
    assign busy       = (state_reg != S_IDLE);
    assign idle_val   = (item_reg.now_time > rd_data_reg.last_seen) ?
                        (item_reg.now_time - rd_data_reg.last_seen) : 40'd0;

    // per-slot decision on the word just read
    always_comb
    begin
        unique case (cmd)
            CMD_CLOSE:
                slot_match = vld && (item_reg.full_ref != 16'd0)
                             && (rd_data_reg.sref == item_reg.full_ref)
                             && (mask_reg == '0);
            CMD_TOUCH:
                slot_match = vld && (rd_data_reg.sref[7:0] == item_reg.short_id);
            CMD_SWEEP:
                slot_match = vld && ({1'b0, item_reg.now_time} >=
                             ({1'b0, rd_data_reg.last_seen} + {1'b0, cfg.idle_timeout}));
            CMD_CLOSE_ALL:
                slot_match = vld;
            CMD_QUERY:
                slot_match = vld && (rd_data_reg.sref[7:0] == item_reg.short_id)
                             && (mask_reg == '0);
            CMD_SLOT_INFO:
                slot_match = vld && (int'(idx_reg) == int'(item_reg.slot_index));
            default:
                slot_match = 1'b0;
        endcase
        mask_next = mask_reg | (SESSIONS'(slot_match) << idx_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_SCAN_RD;
            S_SCAN_RD:
                state_next = S_SCAN_CHK;
            S_SCAN_CHK:
                if (!scan_last)
                    state_next = S_SCAN_RD;
                else if (notice_cmd && (mask_next != '0))
                    state_next = S_EMIT_RD;
                else
                    state_next = S_REPLY_RD;
            S_EMIT_RD:
                state_next = S_EMIT_OUT;
            S_EMIT_OUT:
                state_next = (emit_rest == '0) ? S_REPLY_RD : S_EMIT_RD;
            S_REPLY_RD:
                state_next = S_REPLY;
            S_REPLY:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs: memory ports and result word
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data_reg;
        res_strobe = 1'b0;
        res        = '0;
        res.any_open = |valid_reg;
        unique case (state_reg)
            S_SCAN_RD:
                rd_en = 1'b1;
            S_SCAN_CHK:
                if (cmd == CMD_TOUCH && slot_match)
                begin
                    wr_en             = 1'b1;
                    wr_data.last_seen = item_reg.now_time;
                end
            S_EMIT_RD, S_REPLY_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = emit_idx;
            end
            S_EMIT_OUT:
            begin
                res_strobe      = 1'b1;
                res.kind        = KIND_NOTICE;
                res.status      = STAT_OK;
                res.ref_out     = rd_data_reg.sref;
                res.id_out      = rd_data_reg.sref[7:0];
                res.node_out    = rd_data_reg.node;
                res.wss_out     = rd_data_reg.wss;
                res.version_out = rd_data_reg.version;
                res.idle_time   = idle_val;
            end
            S_REPLY:
            begin
                res_strobe = 1'b1;
                res.kind   = KIND_REPLY;
                res.last   = 1'b1;
                res.status = STAT_OK;
                unique case (cmd)
                    CMD_OPEN:
                        if (free_any)
                        begin
                            wr_en             = 1'b1;
                            wr_addr           = free_idx;
                            wr_data.sref      = next_ref_reg;
                            wr_data.node      = item_reg.peer_node;
                            wr_data.wss       = item_reg.client_socket;
                            wr_data.version   = item_reg.proto_version;
                            wr_data.last_seen = item_reg.now_time;
                            res.ref_out       = next_ref_reg;
                            res.id_out        = next_ref_reg[7:0];
                            res.socket_out    = cfg.server_socket;
                            res.node_out      = item_reg.peer_node;
                            res.wss_out       = item_reg.client_socket;
                            res.version_out   = item_reg.proto_version;
                            res.any_open      = 1'b1;
                        end
                        else
                            res.status = STAT_NO_FREE;
                    CMD_CLOSE:
                    begin
                        res.ref_out = item_reg.full_ref;
                        res.id_out  = item_reg.full_ref[7:0];
                    end
                    CMD_TOUCH:
                        if (mask_reg != '0)
                            res.id_out = item_reg.short_id;
                        else
                            res.status = STAT_NOT_FOUND;
                    CMD_QUERY, CMD_SLOT_INFO:
                        if (mask_reg != '0)
                        begin
                            res.ref_out     = rd_data_reg.sref;
                            res.id_out      = rd_data_reg.sref[7:0];
                            res.node_out    = rd_data_reg.node;
                            res.wss_out     = rd_data_reg.wss;
                            res.version_out = rd_data_reg.version;
                            res.idle_time   = idle_val;
                        end
                        else
                            res.status = STAT_NOT_FOUND;
                    CMD_LOAD_REF:
                        res.ref_out = (item_reg.full_ref != 16'd0) ?
                                      item_reg.full_ref : next_ref_reg;
                    default:
                        res.status = STAT_OK;
                endcase
            end
            default:
                rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            mask_reg     <= '0;
            valid_reg    <= '0;
            next_ref_reg <= REF_START;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        idx_reg  <= '0;
                        mask_reg <= '0;
                    end
                S_SCAN_CHK:
                begin
                    mask_reg <= mask_next;
                    if (!scan_last)
                        idx_reg <= idx_reg + IW'(1);
                    else if (notice_cmd)
                        valid_reg <= valid_reg & ~mask_next;
                end
                S_EMIT_OUT:
                    mask_reg <= emit_rest;
                S_REPLY:
                begin
                    if (cmd == CMD_OPEN && free_any)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        next_ref_reg        <= next_ref_reg + 16'd1;
                    end
                    if (cmd == CMD_LOAD_REF && item_reg.full_ref != 16'd0)
                        next_ref_reg <= item_reg.full_ref;
                end
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= slot_mem[rd_addr];
    end

`ifndef NO_ASSERTIONS
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_OUT) |-> (mask_reg != '0))
        else $error("notice emitted with empty close mask");

    a_emit_slots_freed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD) |-> ((valid_reg & mask_reg) == '0))
        else $error("slot still valid while its notice is pending");

    a_open_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == S_REPLY) |-> !valid_reg[wr_addr])
        else $error("open overwrites a live session");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && res.last) |=> !busy)
        else $error("engine still busy after final word");
`endif

endmodule

`default_nettype wire

[design/session_table_with_idle_expiry_top.sv]
`default_nettype none

// after start is taken the engine reads and checks each slot in turn, then, for a close, sweep
// or close-all, reads and emits a notice for each matched slot, then reads and sends the reply
// a new command is taken only while busy is low, once the engine has sent the reply of the last one
// results leave through an output register for one cycle each; the receiver cannot stall
// reset (rst_n, async, active low) empties the table and sets the reference counter to 0x0021

module session_table_with_idle_expiry_top
    import stwie_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command side
    input  wire logic              start,
    input  item_t                  item,
    output logic                   busy,
    // result side
    output logic                   result_valid,
    output result_t                result,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t    cfg;
    logic    eng_strobe;
    result_t eng_res;
    logic    result_valid_reg;
    result_t result_reg;

    // server socket and idle timeout registers
    stwie_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer around the slot memory: scan, then notices, then the reply
    stwie_engine #(
        .SESSIONS (SESSIONS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .cfg        (cfg),
        .busy       (busy),
        .res_strobe (eng_strobe),
        .res        (eng_res)
    );

    // output register: result_valid is high for exactly one cycle per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= eng_strobe;
    end

    always_ff @(posedge clk)
    begin
        if (eng_strobe)
            result_reg <= eng_res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
